@@ hdl/bbr_pkg.sv @@
// Shared types and constants of the block byte reverser.
package bbr_pkg;

	// Fixed field widths.
	localparam int BYTE_W = 8;
	localparam int CFG_W = 7;

	// Lower stride limit and reset value of the stride register.
	localparam int STRIDE_MIN = 2;
	localparam int GROUP_LENGTH_RESET = 2;

	// Result queue in the back part.
	localparam int OUT_DEPTH = 4;
	localparam int OUT_PTR_W = 2;
	localparam int OUT_CNT_W = 3;

	// Write request from the front part into the group buffer.
	typedef struct packed {
		logic              en;
		logic              bank;
		logic [BYTE_W-1:0] data;
	} wr_req_t;

	// Flags of one closed group waiting to be emitted.
	typedef struct packed {
		logic bank;
		logic reverse;
		logic eot;
	} desc_flags_t;

	// Notice from the back part that a buffer bank has been read out.
	typedef struct packed {
		logic valid;
		logic bank;
	} bank_rel_t;

endpackage

@@ hdl/block_byte_reverser.sv @@
// Top level of the block byte reverser.
//
//  Channel   Direction  Handshake              Payload
//  input     in         push / full            text_byte, end_of_text
//  result    out        pop / empty            out_byte, run_last, text_done
//  config    in         group_length_we        group_length
//
// A request is taken in any cycle in which full is low; a byte is written into one
// bank of a two-bank group buffer while the other bank is read out, one result a
// cycle while the result queue has room. A closed group passes through the group
// queue, the registered buffer read and the result queue before it can be popped;
// steady throughput is one byte per cycle, set by the single buffer read port.
// Full rises only when both banks still hold groups not yet read out.
// Reset clears the fill count, bank ownership and all queues; the stride resets to 2.
module block_byte_reverser #(
	parameter int MAX_GROUP = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic [bbr_pkg::BYTE_W-1:0] text_byte,
	input  logic                       end_of_text,
	output logic                       empty,
	input  logic                       pop,
	output logic [bbr_pkg::BYTE_W-1:0] out_byte,
	output logic                       run_last,
	output logic                       text_done,
	input  logic                       group_length_we,
	input  logic [bbr_pkg::CFG_W-1:0]  group_length
);
	import bbr_pkg::*;

	localparam int CW = $clog2(MAX_GROUP + 1);
	localparam int AW = (MAX_GROUP > 2) ? $clog2(MAX_GROUP) : 1;

	wr_req_t     wr;
	logic [AW-1:0] wr_addr;
	logic        q_push;
	desc_flags_t q_flags;
	logic [CW-1:0] q_count;
	logic        q_pop;
	logic        q_empty;
	logic        q_full;
	desc_flags_t head_flags;
	logic [CW-1:0] head_count;
	bank_rel_t   rel;

	// Front part: takes requests and closes groups.
	bbr_front #(
		.MAX_GROUP(MAX_GROUP),
		.CW(CW),
		.AW(AW)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.group_length_we(group_length_we),
		.group_length(group_length),
		.push(push),
		.text_byte(text_byte),
		.end_of_text(end_of_text),
		.full(full),
		.wr(wr),
		.wr_addr(wr_addr),
		.q_push(q_push),
		.q_flags(q_flags),
		.q_count(q_count),
		.rel(rel)
	);

	// Queue of closed groups.
	bbr_desc_queue #(
		.CW(CW)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.q_push(q_push),
		.q_flags(q_flags),
		.q_count(q_count),
		.q_pop(q_pop),
		.q_empty(q_empty),
		.q_full(q_full),
		.head_flags(head_flags),
		.head_count(head_count)
	);

	// Back part: reads groups out in output order.
	bbr_back #(
		.MAX_GROUP(MAX_GROUP),
		.CW(CW),
		.AW(AW)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.wr(wr),
		.wr_addr(wr_addr),
		.q_empty(q_empty),
		.head_flags(head_flags),
		.head_count(head_count),
		.q_pop(q_pop),
		.rel(rel),
		.empty(empty),
		.pop(pop),
		.out_byte(out_byte),
		.run_last(run_last),
		.text_done(text_done)
	);

	// A closed group always finds a free slot, since each slot matches a bank.
	a_no_queue_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("group queue overflow");

	// A bank is released only while a group is being read out.
	a_release_has_group: assert property (@(posedge clk) disable iff (!arst_n)
		rel.valid |-> !q_empty)
		else $error("bank released with no group pending");

	// An accepted end of text always leaves a group waiting in the queue.
	a_eot_closes_group: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && end_of_text) |=> !q_empty)
		else $error("end of text did not close a group");

endmodule

@@ hdl/bbr_front.sv @@
// Front part: stride register, group filling and group classification.
module bbr_front #(
	parameter int MAX_GROUP = 64,
	parameter int CW = $clog2(MAX_GROUP + 1),
	parameter int AW = (MAX_GROUP > 2) ? $clog2(MAX_GROUP) : 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    group_length_we,
	input  logic [bbr_pkg::CFG_W-1:0] group_length,
	input  logic                    push,
	input  logic [bbr_pkg::BYTE_W-1:0] text_byte,
	input  logic                    end_of_text,
	output logic                    full,
	output bbr_pkg::wr_req_t        wr,
	output logic [AW-1:0]           wr_addr,
	output logic                    q_push,
	output bbr_pkg::desc_flags_t    q_flags,
	output logic [CW-1:0]           q_count,
	input  bbr_pkg::bank_rel_t      rel
);
	import bbr_pkg::*;

	localparam int SW = (CW > CFG_W) ? CW : CFG_W;

	logic [CFG_W-1:0] group_length_q;
	logic [CW-1:0]    fill_q;
	logic             cur_q;
	logic [1:0]       busy_q;

	logic          accept;
	logic [CW-1:0] fill_nxt;
	logic [SW-1:0] gl_ext;
	logic [SW-1:0] stride;
	logic          reverse;
	logic          close;

	// Stride register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_length_q <= CFG_W'(GROUP_LENGTH_RESET);
		end else if (group_length_we) begin
			group_length_q <= group_length;
		end
	end

	// Effective stride, clamped into the legal range.
	always_comb begin
		gl_ext = SW'(group_length_q);
		if (gl_ext < SW'(STRIDE_MIN)) begin
			stride = SW'(STRIDE_MIN);
		end else if (gl_ext > SW'(MAX_GROUP)) begin
			stride = SW'(MAX_GROUP);
		end else begin
			stride = gl_ext;
		end
	end

	// A request is taken only while the current bank is free.
	assign full = busy_q[cur_q];
	assign accept = push && !full;
	assign fill_nxt = fill_q + CW'(1);
	assign reverse = SW'(fill_nxt) >= stride;
	assign close = accept && (reverse || end_of_text);

	// Buffer write and group descriptor.
	always_comb begin
		wr.en = accept;
		wr.bank = cur_q;
		wr.data = text_byte;
		wr_addr = fill_q[AW-1:0];
		q_push = close;
		q_flags.bank = cur_q;
		q_flags.reverse = reverse;
		q_flags.eot = end_of_text;
		q_count = fill_nxt;
	end

	// Fill count, current bank and bank ownership.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			cur_q <= 1'b0;
			busy_q <= '0;
		end else begin
			if (rel.valid) begin
				busy_q[rel.bank] <= 1'b0;
			end
			if (close) begin
				fill_q <= '0;
				cur_q <= !cur_q;
				busy_q[cur_q] <= 1'b1;
			end else if (accept) begin
				fill_q <= fill_nxt;
			end
		end
	end

endmodule

@@ hdl/bbr_desc_queue.sv @@
// Two-entry queue of closed groups between the front and the back part.
module bbr_desc_queue #(
	parameter int CW = 7
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_push,
	input  bbr_pkg::desc_flags_t q_flags,
	input  logic [CW-1:0]        q_count,
	input  logic                 q_pop,
	output logic                 q_empty,
	output logic                 q_full,
	output bbr_pkg::desc_flags_t head_flags,
	output logic [CW-1:0]        head_count
);
	import bbr_pkg::*;

	desc_flags_t   flags_q [2];
	logic [CW-1:0] count_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    cnt_q;

	assign q_empty = (cnt_q == 2'd0);
	assign q_full = (cnt_q == 2'd2);
	assign head_flags = flags_q[rd_ptr_q];
	assign head_count = count_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (q_push) begin
			flags_q[wr_ptr_q] <= q_flags;
			count_q[wr_ptr_q] <= q_count;
		end
	end

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (q_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(q_push) - 2'(q_pop);
		end
	end

endmodule

@@ hdl/bbr_back.sv @@
// Back part: group buffer, read-out sequencer and result queue.
module bbr_back #(
	parameter int MAX_GROUP = 64,
	parameter int CW = $clog2(MAX_GROUP + 1),
	parameter int AW = (MAX_GROUP > 2) ? $clog2(MAX_GROUP) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bbr_pkg::wr_req_t     wr,
	input  logic [AW-1:0]        wr_addr,
	input  logic                 q_empty,
	input  bbr_pkg::desc_flags_t head_flags,
	input  logic [CW-1:0]        head_count,
	output logic                 q_pop,
	output bbr_pkg::bank_rel_t   rel,
	output logic                 empty,
	input  logic                 pop,
	output logic [bbr_pkg::BYTE_W-1:0] out_byte,
	output logic                 run_last,
	output logic                 text_done
);
	import bbr_pkg::*;

	// Group buffer: two banks, each MAX_GROUP bytes rounded up to a power of two.
	logic [BYTE_W-1:0] mem [2*(2**AW)];

	logic [AW-1:0]    k_q;
	logic [CW-1:0]    n_m1;
	logic [AW-1:0]    rd_addr;
	logic             last;
	logic             issue;
	logic [OUT_CNT_W:0] room_sum;

	logic [BYTE_W-1:0] rd_data_s1;
	logic              valid_s1;
	logic              last_s1;
	logic              done_s1;

	logic [BYTE_W-1:0] ob_byte_q [OUT_DEPTH];
	logic              ob_last_q [OUT_DEPTH];
	logic              ob_done_q [OUT_DEPTH];
	logic [OUT_PTR_W-1:0] ob_wr_q;
	logic [OUT_PTR_W-1:0] ob_rd_q;
	logic [OUT_CNT_W-1:0] ob_cnt_q;
	logic                 ob_pop;

	// Buffer write port.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[{wr.bank, wr_addr}] <= wr.data;
		end
	end

	// Read-out sequencing of the group at the head of the queue.
	assign n_m1 = head_count - CW'(1);
	assign last = (CW'(k_q) == n_m1);
	assign rd_addr = head_flags.reverse ? (n_m1[AW-1:0] - k_q) : k_q;
	assign room_sum = (OUT_CNT_W+1)'(ob_cnt_q) + (OUT_CNT_W+1)'(valid_s1);
	assign issue = !q_empty && (room_sum < (OUT_CNT_W+1)'(OUT_DEPTH));
	assign q_pop = issue && last;

	always_comb begin
		rel.valid = issue && last;
		rel.bank = head_flags.bank;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
		end else if (issue) begin
			k_q <= last ? '0 : k_q + AW'(1);
		end
	end

	// Registered buffer read with its flags.
	always_ff @(posedge clk) begin
		if (issue) begin
			rd_data_s1 <= mem[{head_flags.bank, rd_addr}];
			last_s1 <= last;
			done_s1 <= last && head_flags.eot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= issue;
		end
	end

	// Result queue toward the consumer.
	assign empty = (ob_cnt_q == '0);
	assign ob_pop = pop && !empty;
	assign out_byte = ob_byte_q[ob_rd_q];
	assign run_last = ob_last_q[ob_rd_q];
	assign text_done = ob_done_q[ob_rd_q];

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			ob_byte_q[ob_wr_q] <= rd_data_s1;
			ob_last_q[ob_wr_q] <= last_s1;
			ob_done_q[ob_wr_q] <= done_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ob_wr_q <= '0;
			ob_rd_q <= '0;
			ob_cnt_q <= '0;
		end else begin
			if (valid_s1) begin
				ob_wr_q <= ob_wr_q + OUT_PTR_W'(1);
			end
			if (ob_pop) begin
				ob_rd_q <= ob_rd_q + OUT_PTR_W'(1);
			end
			ob_cnt_q <= ob_cnt_q + OUT_CNT_W'(valid_s1) - OUT_CNT_W'(ob_pop);
		end
	end

endmodule

@@ dv/bbr_result_checker.sv @@
// Checker of the block byte reverser: predicts every result byte and compares it.
`timescale 1ns / 100ps
module bbr_result_checker #(
	parameter int MAX_GROUP = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic                       full,
	input  logic [bbr_pkg::BYTE_W-1:0] text_byte,
	input  logic                       end_of_text,
	input  logic                       empty,
	input  logic                       pop,
	input  logic [bbr_pkg::BYTE_W-1:0] out_byte,
	input  logic                       run_last,
	input  logic                       text_done,
	input  logic                       group_length_we,
	input  logic [bbr_pkg::CFG_W-1:0]  group_length,
	output int                         errors,
	output int                         pending,
	output int                         checked
);
	import bbr_pkg::*;

	// One predicted result byte with its flags.
	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              run_last;
		logic              text_done;
	} out_item_t;

	out_item_t         out_stream_q[$];
	logic [BYTE_W-1:0] group_hold [MAX_GROUP];
	int                held = 0;
	logic [CFG_W-1:0]  stride_reg = CFG_W'(GROUP_LENGTH_RESET);
	int                mismatch_count = 0;
	int                result_count = 0;

	assign errors = mismatch_count;
	assign checked = result_count;
	assign pending = out_stream_q.size();

	// The stride register clamped to the range the block supports.
	function automatic int stride_in_use();
		int span;
		span = int'(stride_reg);
		if (span < STRIDE_MIN)
			span = STRIDE_MIN;
		if (span > MAX_GROUP)
			span = MAX_GROUP;
		return span;
	endfunction

	// Append one text byte to the group and queue whatever it releases.
	task automatic take_byte(input logic [BYTE_W-1:0] b, input logic eot);
		int        span;
		bit        backward;
		out_item_t item;
		span = stride_in_use();
		if (held < MAX_GROUP) begin
			group_hold[held] = b;
			held++;
		end
		if (held >= span || eot) begin
			// A full group leaves reversed; a partial group closed by end of text leaves as is.
			backward = (held >= span);
			for (int k = 0; k < held; k++) begin
				item.data = group_hold[backward ? held - 1 - k : k];
				item.run_last = (k + 1 == held);
				item.text_done = (k + 1 == held) && eot;
				out_stream_q.push_back(item);
			end
			held = 0;
		end
	endtask

	// Watch all three channels at each rising edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stride_reg = CFG_W'(GROUP_LENGTH_RESET);
			held = 0;
			out_stream_q.delete();
		end else begin
			// A request in the same cycle as a stride write still sees the old stride.
			if (push && !full)
				take_byte(text_byte, end_of_text);
			if (group_length_we)
				stride_reg = group_length;
			if (pop && !empty) begin
				out_item_t want;
				if (out_stream_q.size() == 0) begin
					mismatch_count++;
					$display("%0t: unexpected result, expected none, got byte %02h last %0b done %0b",
						$time, out_byte, run_last, text_done);
				end else begin
					want = out_stream_q.pop_front();
					result_count++;
					if (out_byte !== want.data) begin
						mismatch_count++;
						$display("%0t: out_byte mismatch, expected %02h, got %02h",
							$time, want.data, out_byte);
					end
					if (run_last !== want.run_last) begin
						mismatch_count++;
						$display("%0t: run_last mismatch, expected %0b, got %0b",
							$time, want.run_last, run_last);
					end
					if (text_done !== want.text_done) begin
						mismatch_count++;
						$display("%0t: text_done mismatch, expected %0b, got %0b",
							$time, want.text_done, text_done);
					end
				end
			end
		end
	end

endmodule

@@ dv/tb_block_byte_reverser.sv @@
// Testbench top of the block byte reverser: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb_block_byte_reverser;
	import bbr_pkg::*;

	localparam int MAX_GROUP = 64;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int RANDOM_ITEMS = 8;
	localparam int IDLE_PCT = 37;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              push = 1'b0;
	logic              full;
	logic [BYTE_W-1:0] text_byte = '0;
	logic              end_of_text = 1'b0;
	logic              empty;
	logic              pop = 1'b0;
	logic [BYTE_W-1:0] out_byte;
	logic              run_last;
	logic              text_done;
	logic              group_length_we = 1'b0;
	logic [CFG_W-1:0]  group_length = '0;

	int errors;
	int pending;
	int checked;
	int sent = 0;
	int random_sent = 0;
	bit steady = 1'b0;
	bit stall_req = 1'b0;

	// 10 ns clock.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	block_byte_reverser #(.MAX_GROUP(MAX_GROUP)) dut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .text_byte(text_byte), .end_of_text(end_of_text),
		.empty(empty), .pop(pop), .out_byte(out_byte), .run_last(run_last),
		.text_done(text_done),
		.group_length_we(group_length_we), .group_length(group_length)
	);

	bbr_result_checker #(.MAX_GROUP(MAX_GROUP)) u_result_check (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .text_byte(text_byte), .end_of_text(end_of_text),
		.empty(empty), .pop(pop), .out_byte(out_byte), .run_last(run_last),
		.text_done(text_done),
		.group_length_we(group_length_we), .group_length(group_length),
		.errors(errors), .pending(pending), .checked(checked)
	);

	// Result side: random pops, with a long hold-off whenever one is requested.
	initial begin
		int stall_cycles;
		forever begin
			@(negedge clk);
			if (stall_req) begin
				pop <= 1'b0;
				stall_cycles = 0;
				while (stall_cycles < HOLD_OFF_CYCLES) begin
					@(negedge clk);
					stall_cycles++;
				end
				stall_req = 1'b0;
			end
			pop <= steady || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Offer one byte, idling at random first, and wait until it is taken.
	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eot);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		text_byte <= b;
		end_of_text <= eot;
		@(posedge clk);
		while (full)
			@(posedge clk);
		sent++;
		@(negedge clk);
	endtask

	// Stop offering and wait until every predicted result has been popped.
	task automatic wait_drained();
		push <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Change the stride only while the block is idle.
	task automatic write_stride(input logic [CFG_W-1:0] v);
		wait_drained();
		group_length_we <= 1'b1;
		group_length <= v;
		@(negedge clk);
		group_length_we <= 1'b0;
	endtask

	// Random text of n bytes; end of text falls at random and sometimes on the last byte.
	task automatic send_text(input int n, input bit close_last);
		bit eot;
		for (int i = 0; i < n; i++) begin
			eot = ($urandom_range(99) < 12) || (close_last && i == n - 1);
			send_byte(BYTE_W'($urandom_range(255)), eot);
			random_sent++;
		end
	endtask

	// Run out of time: fail.
	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles with %0d results pending", cycles, pending);
		$display("end of test: mismatches");
		$finish;
	end

	// Main stimulus.
	initial begin
		int n;
		int stride;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset stride of two: extreme byte values make one reversed pair.
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		// A lone byte closed by end of text.
		send_byte(8'hA5, 1'b1);

		// Partial group at end of text keeps its order; then end on a full group.
		write_stride(CFG_W'(5));
		send_byte(8'h01, 1'b0);
		send_byte(8'h02, 1'b0);
		send_byte(8'h03, 1'b1);
		for (int i = 0; i < 5; i++)
			send_byte(BYTE_W'(8'h10 + i), i == 4);

		// Stride lowered below the held count releases everything reversed.
		write_stride(CFG_W'(8));
		for (int i = 0; i < 5; i++)
			send_byte(BYTE_W'(8'h80 + i), 1'b0);
		write_stride(CFG_W'(3));
		send_byte(8'h7F, 1'b0);

		// Strides of zero and one act as two.
		write_stride(CFG_W'(0));
		send_byte(8'h55, 1'b0);
		send_byte(8'hAA, 1'b0);
		write_stride(CFG_W'(1));
		send_byte(8'h00, 1'b1);
		send_byte(8'h3C, 1'b0);
		send_byte(8'hC3, 1'b0);

		// Largest group: the top stride clamps to the buffer size, then a
		// stride drop releases all 64 held bytes at once.
		write_stride(CFG_W'(127));
		for (int i = 0; i < MAX_GROUP - 1; i++)
			send_byte(BYTE_W'($urandom_range(255)), 1'b0);
		wait_drained();
		write_stride(CFG_W'(0));
		send_byte(BYTE_W'($urandom_range(255)), 1'b0);
		write_stride(CFG_W'(MAX_GROUP));
		send_text(10, 1'b1);

		// Back-pressure: the receiver holds off while the sender keeps going.
		write_stride(CFG_W'(4));
		stall_req = 1'b1;
		send_text(16, 1'b1);

		// A stretch with no idling on either side.
		write_stride(CFG_W'(6));
		steady = 1'b1;
		send_text(12, 1'b1);
		steady = 1'b0;

		// Random phases, mostly short strides.
		random_sent = 0;
		while (random_sent < RANDOM_ITEMS) begin
			if ($urandom_range(9) == 0)
				stride = $urandom_range(1);
			else
				stride = $urandom_range(9, 2);
			write_stride(CFG_W'(stride));
			n = $urandom_range(10, 4);
			send_text(n, 1'($urandom_range(1)));
		end

		// Drain and let the pipeline settle.
		wait_drained();
		repeat (20) @(negedge clk);

		$display("Sent %0d text bytes and checked %0d result bytes over strides 0 to 127,",
			sent, checked);
		$display("with a 64-byte group, a lowered stride, a receiver hold-off and idle gaps.");
		if (errors == 0 && pending == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
